// ===== rtl/sobel_edge_magnitude_rgb_unit_macros.svh =====
// assertion macros for the sobel edge magnitude unit
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_UNIT_MACROS_SVH
// implication checked each clock outside reset
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define SEM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/sem_pkg.sv =====
// shared type, constants and function of the sobel edge magnitude unit
package sem_pkg;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam logic [11:0] WIDTH_RST = 12'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [12:0] HEIGHT_MAX = 13'd4096;
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  localparam logic [7:0] SAT_VAL = 8'd255;

  // one 3x3 window with its last flag, queued between front and back
  typedef struct packed {
    logic [2:0][23:0] lf;
    logic [2:0][23:0] ce;
    logic [2:0][23:0] rt;
    logic last;
  } win_t;

  // sum of the squared gradients of one channel
  function automatic logic [20:0] chan_sum(input logic [2:0][7:0] l,
                                           input logic [2:0][7:0] c,
                                           input logic [2:0][7:0] r);
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [19:0] ax;
    logic [19:0] ay;
    gx = $signed({3'b0, r[0]} + {2'b0, r[1], 1'b0} + {3'b0, r[2]})
       - $signed({3'b0, l[0]} + {2'b0, l[1], 1'b0} + {3'b0, l[2]});
    gy = $signed({3'b0, l[2]} + {2'b0, c[2], 1'b0} + {3'b0, r[2]})
       - $signed({3'b0, l[0]} + {2'b0, c[0], 1'b0} + {3'b0, r[0]});
    ax = 20'(gx * gx);
    ay = 20'(gy * gy);
    return {1'b0, ax} + {1'b0, ay};
  endfunction
endpackage

// ===== rtl/sem_front.sv =====
// front: counters, line buffers, window and frame bookkeeping
module sem_front #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_opcode,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [12:0] cfg_data,
  output logic q_valid,
  output sem_pkg::win_t q_data,
  input  logic q_full
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] lower_mem [MAX_WIDTH];
  logic [23:0] up_rd_r, lo_rd_r;
  logic [1:0] st_r, st_nxt;
  logic [11:0] fw_r;
  logic [12:0] fh_r;
  logic [AW:0] in_col_r, out_col_r;
  logic [12:0] in_row_r, out_row_r;
  logic [2:0][23:0] w_r;
  logic [2:0][23:0] w0_r;
  logic [2:0][23:0] w1_r;
  logic [23:0] px_r;
  logic drain_r;
  logic [AW:0] w_used;
  logic [12:0] h_used;
  logic [AW-1:0] addr;
  logic take;
  logic [23:0] top, mid, bot;
  logic emit_a, emit_b, eb_pend_r;
  logic last_flag;

  always_comb begin
    if (fw_r < 12'd2) w_used = (AW+1)'(2);
    else if (32'(fw_r) > 32'(MAX_WIDTH)) w_used = (AW+1)'(MAX_WIDTH);
    else w_used = (AW+1)'(fw_r);
    if (fh_r < 13'd2) h_used = 13'd2;
    else if (fh_r > sem_pkg::HEIGHT_MAX) h_used = sem_pkg::HEIGHT_MAX;
    else h_used = fh_r;
  end

  assign addr = in_col_r[AW-1:0];
  assign cfg_ready = (st_r == ST_IDLE);
  assign in_stall = (st_r != ST_IDLE) || cfg_valid;
  assign take = in_valid && !in_stall;
  assign last_flag = (out_row_r >= h_used - 13'd1) && (out_col_r >= w_used - 1'b1);

  always_comb begin
    if (in_row_r == 13'd0) begin
      top = px_r; mid = px_r; bot = px_r;
    end else if (in_row_r == 13'd1) begin
      top = px_r; mid = lo_rd_r; bot = px_r;
    end else if (!drain_r) begin
      top = up_rd_r; mid = lo_rd_r; bot = px_r;
    end else begin
      top = up_rd_r; mid = lo_rd_r; bot = up_rd_r;
    end
  end

  assign emit_a = (in_col_r == '0) && (in_row_r >= 13'd2);
  assign emit_b = (in_row_r <= h_used) && (in_col_r != '0) && (in_row_r != 13'd0);

  always_comb begin
    st_nxt = st_r;
    q_valid = 1'b0;
    q_data = '0;
    case (st_r)
      ST_IDLE: if (take && !(in_row_r < h_used && in_opcode)) st_nxt = ST_READ;
      ST_READ: begin
        if (emit_a) begin
          q_data.lf = w1_r; q_data.ce = w_r; q_data.rt = w1_r;
          q_data.last = last_flag;
          q_valid = !q_full;
        end
        if (!emit_a || !q_full) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (eb_pend_r) begin
          q_data.lf = (in_col_r == (AW+1)'(1)) ? w_r : w0_r;
          q_data.ce = w1_r; q_data.rt = w_r;
          q_data.last = last_flag;
          q_valid = !q_full;
        end
        if (!eb_pend_r || !q_full) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      up_rd_r <= upper_mem[addr];
      lo_rd_r <= lower_mem[addr];
      px_r <= {in_blue_in, in_green_in, in_red_in};
    end
    if (st_r == ST_READ && (!emit_a || !q_full) && in_row_r < h_used && !drain_r) begin
      if (in_row_r >= 13'd1) upper_mem[addr] <= lo_rd_r;
      lower_mem[addr] <= px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      fw_r <= sem_pkg::WIDTH_RST;
      fh_r <= sem_pkg::HEIGHT_RST;
      in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
      w_r <= '0; w0_r <= '0; w1_r <= '0;
      drain_r <= 1'b0;
      eb_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sem_pkg::CFG_WIDTH) fw_r <= cfg_data[11:0];
        else fh_r <= cfg_data;
        in_col_r <= '0; in_row_r <= '0; out_col_r <= '0; out_row_r <= '0;
      end
      if (take) drain_r <= (in_row_r >= h_used);
      if (q_valid) begin
        if (q_data.last) begin
          out_row_r <= '0; out_col_r <= '0;
        end else if (out_col_r + 1'b1 >= w_used) begin
          out_col_r <= '0; out_row_r <= out_row_r + 13'd1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
      if (st_r == ST_READ && (!emit_a || !q_full)) begin
        if (in_row_r <= h_used) begin
          w0_r <= w1_r; w1_r <= w_r;
          w_r <= {bot, mid, top};
          eb_pend_r <= emit_b;
        end else begin
          eb_pend_r <= 1'b0;
        end
      end
      if (st_r == ST_EMIT && (!eb_pend_r || !q_full)) begin
        if (in_row_r >= h_used + 13'd1) begin
          in_row_r <= '0; in_col_r <= '0;
        end else if (in_col_r + 1'b1 >= w_used) begin
          in_col_r <= '0; in_row_r <= in_row_r + 13'd1;
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/sem_queue.sv =====
// two-entry queue of windows between front and back
module sem_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  sem_pkg::win_t wr_data,
  output logic full,
  output logic rd_valid,
  output sem_pkg::win_t rd_data,
  input  logic rd_en
);
  sem_pkg::win_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= !wp_r;
      if (rd_en) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

// ===== rtl/sem_back.sv =====
// back: gradient sums, serial square root, output register
module sem_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  sem_pkg::win_t q_data,
  output logic q_rd,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_red_edge,
  output logic [7:0] out_green_edge,
  output logic [7:0] out_blue_edge,
  output logic out_frame_end
);
  logic busy_r;
  logic [3:0] step_r;
  logic [2:0][20:0] sum_r;
  logic [2:0][7:0] root_r;
  logic last_r;
  logic [2:0][7:0] l, c, r;
  logic [2:0][20:0] sum_nxt;
  logic [2:0][7:0] root_nxt;
  logic [7:0] bitm;

  assign q_rd = q_valid && !busy_r && !out_valid;
  assign bitm = 8'd128 >> step_r[2:0];

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      for (int k = 0; k < 3; k++) begin
        l[k] = q_data.lf[k][8*s +: 8];
        c[k] = q_data.ce[k][8*s +: 8];
        r[k] = q_data.rt[k][8*s +: 8];
      end
      sum_nxt[s] = sem_pkg::chan_sum(l, c, r);
    end
  end

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      logic [7:0] t;
      t = root_r[s] | bitm;
      root_nxt[s] = ({5'b0, {8'b0, t} * {8'b0, t}} <= sum_r[s]) ? t : root_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      sum_r <= sum_nxt;
      last_r <= q_data.last;
      root_r <= '0;
    end else if (busy_r) begin
      root_r <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; step_r <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (q_rd) begin
        busy_r <= 1'b1; step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'd7) begin
          busy_r <= 1'b0;
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && step_r == 4'd7) begin
      out_red_edge <= sum_r[0][20:16] != '0 ? sem_pkg::SAT_VAL : root_nxt[0];
      out_green_edge <= sum_r[1][20:16] != '0 ? sem_pkg::SAT_VAL : root_nxt[1];
      out_blue_edge <= sum_r[2][20:16] != '0 ? sem_pkg::SAT_VAL : root_nxt[2];
      out_frame_end <= last_r;
    end
  end
endmodule

// ===== rtl/sobel_edge_magnitude_rgb_unit.sv =====
// top level of the sobel edge magnitude unit
// Pixels in raster order; each result is the 3x3 Sobel gradient magnitude per
// color channel, reflect-101 borders, lagging input by frame_width+1 items.
// The front handles each item as a line buffer read, a window update and a
// result hand-off, and takes no new item until those are done; the back loads
// a window, runs its bit-serial square root and holds the result until it is
// taken, and loads no new window while it is busy or holding a result.
module sobel_edge_magnitude_rgb_unit #(
  parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_opcode,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_red_edge,
  output logic [7:0] out_green_edge,
  output logic [7:0] out_blue_edge,
  output logic out_frame_end,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_index,
  input  logic [12:0] cfg_data
);
  logic f_valid, q_full, b_valid, b_rd;
  sem_pkg::win_t f_data, b_data;

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_red_in, .in_green_in,
    .in_blue_in, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_valid(f_valid), .q_data(f_data), .q_full(q_full)
  );

  sem_queue u_queue (
    .clk, .rst_n, .wr_en(f_valid), .wr_data(f_data), .full(q_full),
    .rd_valid(b_valid), .rd_data(b_data), .rd_en(b_rd)
  );

  sem_back u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_data(b_data), .q_rd(b_rd),
    .out_valid, .out_stall, .out_red_edge, .out_green_edge, .out_blue_edge,
    .out_frame_end
  );
endmodule

// ===== rtl/sem_checker.sv =====
// port-level checker for the sobel edge magnitude unit, bound to the top
`include "sobel_edge_magnitude_rgb_unit_macros.svh"
module sem_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_opcode,
  input logic out_valid,
  input logic out_stall,
  input logic [7:0] out_red_edge,
  input logic out_frame_end,
  input logic cfg_valid,
  input logic cfg_ready
);
  `SEM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_red_edge), "stalled result changed")
  `SEM_ASSERT_IMP(a_cfg_blocks_in, clk, rst_n, cfg_valid, in_stall, "input taken during config write")
  `SEM_ASSERT_NXT(a_transfer_gap, clk, rst_n, in_valid && !in_stall && !in_opcode, in_stall, "pixel transfer followed at once by another")
  `SEM_ASSERT_NXT(a_end_gap, clk, rst_n, out_valid && !out_stall && out_frame_end, !out_valid, "result right after frame end")
endmodule

bind sobel_edge_magnitude_rgb_unit sem_checker u_sem_checker (
  .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .out_valid, .out_stall,
  .out_red_edge, .out_frame_end, .cfg_valid, .cfg_ready
);

// ===== test/tb_sobel_edge_magnitude_rgb_unit.sv =====
// testbench for the sobel edge magnitude unit: directed and random frames checked against a scoreboard
module tb_sobel_edge_magnitude_rgb_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic frame_end;
  } edge_pixel_t;

  class sobel_scoreboard;
    logic [23:0] row_upper[sem_pkg::MAX_WIDTH_DEF];
    logic [23:0] row_lower[sem_pkg::MAX_WIDTH_DEF];
    logic [23:0] win[9];
    int unsigned in_col, in_row, out_col, out_row;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    edge_pixel_t pending[$];
    int errors;

    function void clear();
      foreach (win[i]) win[i] = '0;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      width_reg = sem_pkg::WIDTH_RST;
      height_reg = sem_pkg::HEIGHT_RST;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [12:0] value);
      if (idx == sem_pkg::CFG_WIDTH) width_reg = value[11:0];
      else height_reg = value;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function int unsigned wid();
      if (width_reg < 2) return 2;
      if (width_reg > sem_pkg::MAX_WIDTH_DEF) return sem_pkg::MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned hgt();
      if (height_reg < 2) return 2;
      if (height_reg > sem_pkg::HEIGHT_MAX) return sem_pkg::HEIGHT_MAX;
      return height_reg;
    endfunction

    function logic [7:0] floor_root(int unsigned n);
      int unsigned r, t;
      r = 0;
      if (n >= 65536) return sem_pkg::SAT_VAL;
      for (int b = 128; b != 0; b = b >> 1) begin
        t = r | b;
        if (t * t <= n) r = t;
      end
      return r[7:0];
    endfunction

    function int ch(int i, int s);
      return int'(win[i][8*s +: 8]);
    endfunction

    function void predict_result(int l, int c, int rt);
      edge_pixel_t res;
      int gx, gy;
      logic [7:0] mag[3];
      for (int s = 0; s < 3; s++) begin
        gx = (ch(rt, s) + 2 * ch(rt + 1, s) + ch(rt + 2, s))
           - (ch(l, s) + 2 * ch(l + 1, s) + ch(l + 2, s));
        gy = (ch(l + 2, s) + 2 * ch(c + 2, s) + ch(rt + 2, s))
           - (ch(l, s) + 2 * ch(c, s) + ch(rt, s));
        mag[s] = floor_root(gx * gx + gy * gy);
      end
      res.red = mag[0];
      res.green = mag[1];
      res.blue = mag[2];
      if (out_row >= hgt() - 1 && out_col >= wid() - 1) begin
        res.frame_end = 1'b1;
        out_row = 0;
        out_col = 0;
      end else begin
        res.frame_end = 1'b0;
        out_col++;
        if (out_col >= wid()) begin
          out_col = 0;
          out_row++;
        end
      end
      pending.push_back(res);
    endfunction

    function void note_input(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, x, y;
      logic [23:0] px, top, mid, bot;
      w = wid();
      h = hgt();
      x = in_col;
      y = in_row;
      if (x >= w) x = 0;
      if (y < h && op) return;
      if (x == 0 && y >= 2) predict_result(3, 6, 3);
      if (y <= h) begin
        px = (y < h) ? {b, g, r} : '0;
        if (y == 0) begin
          top = px; mid = px; bot = px;
        end else if (y == 1) begin
          top = px; mid = row_lower[x]; bot = px;
        end else if (y < h) begin
          top = row_upper[x]; mid = row_lower[x]; bot = px;
        end else begin
          top = row_upper[x]; mid = row_lower[x]; bot = top;
        end
        if (y < h) begin
          if (y >= 1) row_upper[x] = row_lower[x];
          row_lower[x] = px;
        end
        for (int i = 0; i < 6; i++) win[i] = win[i + 3];
        win[6] = top;
        win[7] = mid;
        win[8] = bot;
        if (x >= 1 && y >= 1) predict_result((x == 1) ? 6 : 0, 3, 6);
      end
      if (y >= h + 1) begin
        in_row = 0;
        in_col = 0;
      end else begin
        x++;
        if (x >= w) begin
          x = 0;
          in_row = y + 1;
        end
        in_col = x;
      end
    endfunction

    function void check_result(edge_pixel_t got);
      edge_pixel_t want;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red) begin
        $error("red_edge expected %0d actual %0d", want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $error("green_edge expected %0d actual %0d", want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue_edge expected %0d actual %0d", want.blue, got.blue);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end expected %0b actual %0b", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_opcode;
  logic [7:0] in_red_in, in_green_in, in_blue_in;
  logic out_valid, out_stall;
  logic [7:0] out_red_edge, out_green_edge, out_blue_edge;
  logic out_frame_end;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [12:0] cfg_data;

  sobel_scoreboard sb;
  int items;
  int cycles;
  int hold_left;
  bit calm;

  sobel_edge_magnitude_rgb_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sobel_edge_magnitude_rgb_unit: FAIL");
      $finish;
    end
  end

  // result side: check transfers, random stall, long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result({out_red_edge, out_green_edge, out_blue_edge, out_frame_end});
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  task automatic push(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, r, g, b);
    items++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [12:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  task automatic set_size(logic [12:0] w, logic [12:0] h);
    wait_idle();
    cfg_write(sem_pkg::CFG_WIDTH, w);
    cfg_write(sem_pkg::CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] sample();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hff : 8'h00;
    return 8'($urandom);
  endfunction

  // full frame of pixels then drain steps; noise adds ignored drains mid-frame
  task automatic run_frame(bit noise);
    int unsigned n;
    n = sb.wid() * sb.hgt();
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(19) == 0) push(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      push(1'b0, sample(), sample(), sample());
    end
    for (int unsigned i = 0; i <= sb.wid(); i++)
      push(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear();
    items = 0;
    cycles = 0;
    hold_left = 0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= 1'b0;
    in_red_in <= '0;
    in_green_in <= '0;
    in_blue_in <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= sem_pkg::CFG_WIDTH;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4x3 pattern of extremes, a drain inside the frame, pixels as drains
    set_size(13'd4, 13'd3);
    for (int i = 0; i < 12; i++) begin
      if (i == 5) push(1'b1, 8'hff, 8'hff, 8'hff);
      push(1'b0, (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'h00 : 8'hff, (i / 4 == 1) ? 8'hff : 8'h00);
    end
    for (int i = 0; i < 5; i++) push(1'(i % 2), 8'hff, 8'h00, 8'hff);
    // widths and heights below the range clamp to two
    set_size(13'd0, 13'd1);
    run_frame(1'b0);
    set_size(13'd1, 13'd0);
    run_frame(1'b1);

    // extremes of both registers, partial frames restarted by register write
    set_size(13'd4095, 13'd2);
    for (int i = 0; i < 100; i++) push(1'b0, sample(), sample(), sample());
    set_size(13'd2, 13'd8191);
    for (int i = 0; i < 100; i++) push(1'b0, sample(), sample(), sample());
    set_size(13'd2048, 13'd4096);
    for (int i = 0; i < 100; i++) push(1'b0, sample(), sample(), sample());
    set_size(13'd2, 13'd4096);
    for (int i = 0; i < 100; i++) push(1'b0, sample(), sample(), sample());

    // long receiver hold-off while the sender keeps offering
    set_size(13'd64, 13'd3);
    hold_left = 800;
    run_frame(1'b0);

    while (items < 1850) begin
      case ($urandom_range(9))
        0: set_size(13'($urandom_range(2, 12)), 13'($urandom_range(2, 7)));
        1: begin
          // broken frame, then a restart by register write
          for (int i = $urandom_range(1, 20); i > 0; i--)
            push(1'($urandom_range(3) == 0), sample(), sample(), sample());
          set_size(13'($urandom_range(2, 12)), 13'($urandom_range(2, 7)));
        end
        2: begin
          calm = 1'b1;
          run_frame(1'b0);
          run_frame(1'b1);
          calm = 1'b0;
        end
        3: begin
          // sender pauses mid-frame until everything is out
          for (int i = $urandom_range(1, 10); i > 0; i--)
            push(1'b0, sample(), sample(), sample());
          wait_idle();
          set_size(13'($urandom_range(2, 12)), 13'($urandom_range(2, 7)));
        end
        default: run_frame($urandom_range(1));
      endcase
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_sobel_edge_magnitude_rgb_unit: PASS");
    end else begin
      $display("tb_sobel_edge_magnitude_rgb_unit: FAIL");
    end
    $finish;
  end
endmodule
